// ===== hw/rtl/hetwa_pkg.sv =====
`timescale 1ns / 1ps
package hetwa_pkg;

    localparam logic [1:0] MODE_UPSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_PING   = 2'd2;
    localparam logic [1:0] MODE_TICK   = 2'd3;

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_REMOVED  = 3'd3;
    localparam logic [2:0] ST_PINGED   = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;
    localparam logic [2:0] ST_TICKDONE = 3'd6;

    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_USED  = 2'd1;
    localparam logic [1:0] SLOT_GONE  = 2'd2;

    localparam logic [31:0] HASH_SEED = 32'd5381;

    localparam logic [15:0] TIMEOUT_RESET = 16'd15;
    localparam logic [7:0]  PERIOD_RESET  = 8'd5;

    // register byte addresses / 4
    localparam logic [0:0] REG_TIMEOUT = 1'b0;
    localparam logic [0:0] REG_PERIOD  = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic start;      // latch item, start hash
        logic hash_step;  // one key byte into hash
        logic probe_init; // probe pointer <= home slot
        logic probe_next; // advance probe pointer
        logic sweep_init; // pointer <= 0
        logic rd;         // issue read at pointer
        logic wr_ins;     // write new entry at pointer
        logic wr_upd;     // write x/y/time at pointer
        logic wr_ping;    // write time at pointer
        logic wr_gone;    // mark pointer gone
        logic evict;      // evict at pointer (sweep)
        logic tick;       // advance time and phase
        logic done;       // load result register
        logic [2:0] status;
        logic report_slot; // result carries slot data
    } hetwa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hash_last;
        logic slot_empty;
        logic slot_match;
        logic slot_free;   // empty or tombstone
        logic probe_last;  // visited all slots
        logic full;
        logic sweep_due;
        logic stale;       // used and timed out
        logic mode_upsert;
        logic mode_remove;
        logic mode_ping;
        logic mode_tick;
    } hetwa_sts_t;

endpackage

// ===== hw/rtl/hetwa_ram.sv =====
`timescale 1ns / 1ps
module hetwa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/hetwa_datapath.sv =====
`timescale 1ns / 1ps
module hetwa_datapath
    import hetwa_pkg::*;
#(
    parameter int SLOTS     = 128,
    parameter int KEY_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  hetwa_cmd_t  cmd,
    output hetwa_sts_t  sts,
    input  logic [1:0]  in_mode,
    input  logic [63:0] in_key,
    input  logic [31:0] in_x,
    input  logic [31:0] in_y,
    input  logic [15:0] timeout_seconds,
    input  logic [7:0]  sweep_period,
    output logic [2:0]  res_status,
    output logic [6:0]  res_slot,
    output logic [31:0] res_x,
    output logic [31:0] res_y,
    output logic [7:0]  res_evicted
);
    localparam int AW = $clog2(SLOTS);
    localparam int BW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [1:0]  mode_reg;
    logic [63:0] key_reg;
    logic [31:0] x_reg, y_reg;
    logic [31:0] hash_reg;
    logic [BW-1:0] byte_reg;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [1:0]  st_reg [SLOTS];
    logic [1:0]  st_rd_reg;
    logic [CW-1:0] occ_reg;
    logic [31:0] now_reg;
    logic [7:0]  phase_reg;
    logic [7:0]  evc_reg;
    logic        sweep_due_reg;

    logic [63:0] key_masked;
    logic [7:0]  cur_byte;
    logic [7:0]  phase_inc;

    logic [63:0] k_rd;
    logic [31:0] x_rd, y_rd, t_rd;
    logic        we_key, we_xy, we_t;
    logic [31:0] idle;

    always_comb
    begin
        if (KEY_BYTES >= 8)
        begin
            key_masked = in_key;
        end
        else
        begin
            key_masked = in_key & ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
        end
    end

    // first byte = most significant used byte
    assign cur_byte = key_reg[8*byte_reg +: 8];

    assign we_key = cmd.wr_ins;
    assign we_xy  = cmd.wr_ins | cmd.wr_upd;
    assign we_t   = cmd.wr_ins | cmd.wr_upd | cmd.wr_ping;

    hetwa_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_key (
        .clk(clk), .we(we_key), .waddr(ptr_reg), .wdata(key_reg),
        .raddr(ptr_reg), .rdata(k_rd));
    hetwa_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_x (
        .clk(clk), .we(we_xy), .waddr(ptr_reg), .wdata(x_reg),
        .raddr(ptr_reg), .rdata(x_rd));
    hetwa_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_y (
        .clk(clk), .we(we_xy), .waddr(ptr_reg), .wdata(y_reg),
        .raddr(ptr_reg), .rdata(y_rd));
    hetwa_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_t (
        .clk(clk), .we(we_t), .waddr(ptr_reg), .wdata(now_reg),
        .raddr(ptr_reg), .rdata(t_rd));

    assign idle = now_reg - t_rd;
    assign phase_inc = phase_reg + 8'd1;

    assign sts.hash_last   = (byte_reg == '0);
    assign sts.slot_empty  = (st_rd_reg == SLOT_EMPTY);
    assign sts.slot_match  = (st_rd_reg == SLOT_USED) && (k_rd == key_reg);
    assign sts.slot_free   = (st_rd_reg != SLOT_USED);
    assign sts.probe_last  = (cnt_reg == AW'(SLOTS - 1));
    assign sts.full        = (occ_reg >= CW'(SLOTS));
    assign sts.sweep_due   = sweep_due_reg;
    assign sts.stale       = (st_rd_reg == SLOT_USED) && (idle > {16'd0, timeout_seconds});
    assign sts.mode_upsert = (mode_reg == MODE_UPSERT);
    assign sts.mode_remove = (mode_reg == MODE_REMOVE);
    assign sts.mode_ping   = (mode_reg == MODE_PING);
    assign sts.mode_tick   = (mode_reg == MODE_TICK);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg <= in_mode;
            key_reg  <= key_masked;
            x_reg    <= in_x;
            y_reg    <= in_y;
        end
        if (cmd.rd)
        begin
            st_rd_reg   <= st_reg[ptr_reg];
            rd_addr_reg <= ptr_reg;
        end
        if (cmd.done)
        begin
            res_status <= cmd.status;
            res_slot   <= cmd.report_slot ? 7'(rd_addr_reg) : 7'd0;
            res_x      <= !cmd.report_slot ? 32'd0 :
                          (cmd.status == ST_REMOVED || cmd.status == ST_PINGED) ? x_rd : x_reg;
            res_y      <= !cmd.report_slot ? 32'd0 :
                          (cmd.status == ST_REMOVED || cmd.status == ST_PINGED) ? y_rd : y_reg;
            res_evicted <= (cmd.status == ST_TICKDONE) ? evc_reg : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= HASH_SEED;
            byte_reg      <= '0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            occ_reg       <= '0;
            now_reg       <= '0;
            phase_reg     <= '0;
            evc_reg       <= '0;
            sweep_due_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                st_reg[i] <= SLOT_EMPTY;
            end
        end
        else
        begin
            if (cmd.start)
            begin
                hash_reg <= HASH_SEED;
                byte_reg <= BW'(KEY_BYTES - 1);
                evc_reg  <= '0;
            end
            if (cmd.hash_step)
            begin
                hash_reg <= (hash_reg << 5) + hash_reg + {24'd0, cur_byte};
                byte_reg <= byte_reg - BW'(1);
            end
            if (cmd.probe_init)
            begin
                ptr_reg <= hash_reg[AW-1:0];
                cnt_reg <= '0;
            end
            if (cmd.sweep_init)
            begin
                ptr_reg <= '0;
                cnt_reg <= '0;
            end
            if (cmd.probe_next)
            begin
                ptr_reg <= ptr_reg + AW'(1);
                cnt_reg <= cnt_reg + AW'(1);
            end
            if (cmd.wr_ins)
            begin
                st_reg[ptr_reg] <= SLOT_USED;
                occ_reg <= occ_reg + CW'(1);
            end
            if (cmd.wr_gone)
            begin
                st_reg[ptr_reg] <= SLOT_GONE;
                occ_reg <= occ_reg - CW'(1);
            end
            if (cmd.evict)
            begin
                st_reg[rd_addr_reg] <= SLOT_GONE;
                occ_reg <= occ_reg - CW'(1);
                evc_reg <= evc_reg + 8'd1;
            end
            if (cmd.tick)
            begin
                now_reg <= now_reg + 32'd1;
                if (phase_inc >= sweep_period)
                begin
                    phase_reg     <= '0;
                    sweep_due_reg <= 1'b1;
                end
                else
                begin
                    phase_reg     <= phase_inc;
                    sweep_due_reg <= 1'b0;
                end
            end
        end
    end
endmodule

// ===== hw/rtl/hetwa_ctrl.sv =====
`timescale 1ns / 1ps
module hetwa_ctrl
    import hetwa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    output logic       in_ready,
    output logic       res_valid,
    input  logic       res_taken,
    input  hetwa_sts_t sts,
    output hetwa_cmd_t cmd
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_HASH  = 10'b0000000010,
        S_PINIT = 10'b0000000100,
        S_PRD   = 10'b0000001000,
        S_PCHK  = 10'b0000010000,
        S_INS   = 10'b0000100000,
        S_TICK  = 10'b0001000000,
        S_SRD   = 10'b0010000000,
        S_SCHK  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_full_reg, out_full_next;
    logic   ins_pass_reg, ins_pass_next; // second probe pass: find free slot

    assign res_valid = out_full_reg;
    assign in_ready  = (state_reg == S_IDLE) && !out_full_reg;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        ins_pass_next = ins_pass_reg;
        out_full_next = out_full_reg && !res_taken;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.start     = 1'b1;
                    ins_pass_next = 1'b0;
                    state_next    = S_HASH;
                end
            end
            S_HASH:
            begin
                if (sts.mode_tick)
                begin
                    cmd.tick   = 1'b1;
                    state_next = S_TICK;
                end
                else
                begin
                    cmd.hash_step = 1'b1;
                    if (sts.hash_last)
                    begin
                        state_next = S_PINIT;
                    end
                end
            end
            S_PINIT:
            begin
                cmd.probe_init = 1'b1;
                state_next     = S_PRD;
            end
            S_PRD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (!ins_pass_reg)
                begin
                    if (sts.slot_match)
                    begin
                        cmd.report_slot = 1'b1;
                        cmd.done        = 1'b1;
                        state_next      = S_OUT;
                        if (sts.mode_upsert)
                        begin
                            cmd.wr_upd = 1'b1;
                            cmd.status = ST_UPDATED;
                        end
                        else if (sts.mode_remove)
                        begin
                            cmd.wr_gone = 1'b1;
                            cmd.status  = ST_REMOVED;
                        end
                        else
                        begin
                            cmd.wr_ping = 1'b1;
                            cmd.status  = ST_PINGED;
                        end
                    end
                    else if (sts.slot_empty || sts.probe_last)
                    begin
                        if (sts.mode_upsert && !sts.full)
                        begin
                            ins_pass_next = 1'b1;
                            state_next    = S_PINIT;
                        end
                        else
                        begin
                            cmd.done   = 1'b1;
                            cmd.status = sts.mode_upsert ? ST_FULL : ST_NOTFOUND;
                            state_next = S_OUT;
                        end
                    end
                    else
                    begin
                        cmd.probe_next = 1'b1;
                        state_next     = S_PRD;
                    end
                end
                else
                begin
                    if (sts.slot_free)
                    begin
                        cmd.wr_ins      = 1'b1;
                        cmd.done        = 1'b1;
                        cmd.report_slot = 1'b1;
                        cmd.status      = ST_INSERTED;
                        state_next      = S_OUT;
                    end
                    else if (sts.probe_last)
                    begin
                        cmd.done   = 1'b1;
                        cmd.status = ST_FULL;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.probe_next = 1'b1;
                        state_next     = S_PRD;
                    end
                end
            end
            S_INS:
            begin
                state_next = S_OUT;
            end
            S_TICK:
            begin
                if (sts.sweep_due)
                begin
                    cmd.sweep_init = 1'b1;
                    state_next     = S_SRD;
                end
                else
                begin
                    cmd.done   = 1'b1;
                    cmd.status = ST_TICKDONE;
                    state_next = S_OUT;
                end
            end
            S_SRD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (sts.stale)
                begin
                    cmd.evict = 1'b1;
                end
                if (sts.probe_last)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_SRD;
                end
            end
            S_OUT:
            begin
                // sweep finishes here: evicted count is now final
                if (sts.mode_tick && !out_full_reg)
                begin
                    cmd.done   = 1'b1;
                    cmd.status = ST_TICKDONE;
                end
                if (!out_full_reg || res_taken)
                begin
                    out_full_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            out_full_reg <= 1'b0;
            ins_pass_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
            ins_pass_reg <= ins_pass_next;
        end
    end
endmodule

// ===== hw/rtl/hashed_entry_table_with_aging.sv =====
`timescale 1ns / 1ps
// Accept to result valid, update/remove/ping: KEY_BYTES hash steps (8 by default), one
//   pointer load, a read and a check per probed slot, then the output state; an insert
//   adds a second pass (pointer load, then read and check per slot) to find a free slot.
// Tick: time advances, then a sweep if due (single read port walks every slot), then output.
// One item at a time; the next item is accepted only once the result has been taken.
// Reset: all slots empty, counters and time cleared, registers at 15 s / 5 ticks.
module hashed_entry_table_with_aging
    import hetwa_pkg::*;
#(
    parameter int SLOTS     = 128,
    parameter int KEY_BYTES = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    // input item
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // key[63:0], x_bits[95:64], y_bits[127:96]
    input  logic [1:0]   s_tuser,  // mode
    // result item
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,  // slot_index[6:0], stored_x[38:7], stored_y[70:39],
                                   // evicted_count[78:71], zero pad
    output logic [2:0]   m_tuser,  // status
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    hetwa_cmd_t cmd;
    hetwa_sts_t sts;

    logic [15:0] timeout_reg;
    logic [7:0]  period_reg;
    logic [2:0]  res_status;
    logic [6:0]  res_slot;
    logic [31:0] res_x, res_y;
    logic [7:0]  res_evicted;
    logic        in_fire;

    assign pready  = 1'b1;
    assign in_fire = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            period_reg  <= PERIOD_RESET;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0 && paddr[2] == REG_TIMEOUT)
        begin
            timeout_reg <= pwdata[15:0];
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0 && paddr[2] == REG_PERIOD)
        begin
            period_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TIMEOUT: prdata = {16'd0, timeout_reg};
            REG_PERIOD:  prdata = {24'd0, period_reg};
            default:     prdata = 32'd0;
        endcase
    end

    hetwa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_ready(s_tready),
        .res_valid(m_tvalid), .res_taken(m_tready), .sts(sts), .cmd(cmd));

    hetwa_datapath #(.SLOTS(SLOTS), .KEY_BYTES(KEY_BYTES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_mode(s_tuser), .in_key(s_tdata[63:0]), .in_x(s_tdata[95:64]),
        .in_y(s_tdata[127:96]),
        .timeout_seconds(timeout_reg), .sweep_period(period_reg),
        .res_status(res_status), .res_slot(res_slot), .res_x(res_x), .res_y(res_y),
        .res_evicted(res_evicted));

    assign m_tdata = {1'b0, res_evicted, res_y, res_x, res_slot};
    assign m_tuser = res_status;
endmodule
